>>> design/i2crt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the I2C register-transfer master.
// Used by i2crt_core and i2c_register_transfer_master_unit; depends on nothing.
package i2crt_pkg;

    // Defaults for the top-level parameters.
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DELAY_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int BYTE_W       = 8;
    localparam int DEV_ADDR_W   = 7;
    localparam int PHASE_W      = 16;
    localparam int COUNT_IN_W   = 16;
    localparam int ACTION_W     = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int SUB_W        = 3;
    localparam int BIT_CNT_W    = 4;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic               READ_BIT          = 1'b1;

    // Action codes of an input word.
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SUPPLY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEV_ADDR    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS = 1'b1;

    // Steps inside one stage of the bus sequence.
    localparam logic [SUB_W-1:0] SUB_DRIVE    = 3'd0;
    localparam logic [SUB_W-1:0] SUB_HIGH     = 3'd1;
    localparam logic [SUB_W-1:0] SUB_ACK_LOW  = 3'd2;
    localparam logic [SUB_W-1:0] SUB_ACK_HIGH = 3'd3;
    localparam logic [SUB_W-1:0] SUB_ACK_END  = 3'd4;
    localparam logic [SUB_W-1:0] SUB_WAIT     = 3'd5;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_START1 = 8'b0000_0010,
        ST_DEVW   = 8'b0000_0100,
        ST_REG    = 8'b0000_1000,
        ST_START2 = 8'b0001_0000,
        ST_DEVD   = 8'b0010_0000,
        ST_DATA   = 8'b0100_0000,
        ST_STOP   = 8'b1000_0000
    } t_stage;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0] dev_addr;
        logic [PHASE_W-1:0]    phase_ticks;
    } t_cfg;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [BYTE_W-1:0]     reg_addr;
        logic                  read_not_write;
        logic [COUNT_IN_W-1:0] byte_count;
        logic [BYTE_W-1:0]     write_byte;
        logic                  sda_in;
    } t_item;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              write_request;
        logic              busy_res;
        logic              done_res;
        logic              status;
    } t_result;

endpackage

>>> design/i2c_register_transfer_master_unit.sv
`timescale 1ns / 1ps
// Top level of the I2C register-transfer master: handshakes, configuration
// registers and the result register. Depends on i2crt_pkg and i2crt_core.
//
// Usage:
//   Each input word is one tick of the bus sequencer. action selects a plain
//   tick, the start of a register transfer (reg_addr, read_not_write,
//   byte_count) or the supply of the next write byte. Every accepted word
//   yields exactly one result word with the line drives, a received byte
//   when read_valid is set, the write-request, busy and done flags, and the
//   status that goes with done.
//   Input and output channels use valid/stall; a word moves when valid is
//   high and stall is low. The result word is registered and appears in the
//   cycle after its input word is accepted, and one word per cycle is taken
//   when the output side does not stall. If the receiver stalls, the result
//   stays in the output register and the input side stalls until it is taken;
//   the sequencer state only advances on accepted words.
//   The configuration port writes device_address (index 0) and phase_ticks
//   (index 1); it is always ready and is meant to be written while idle.
//   Synchronous active-low reset returns the sequencer to idle with both
//   lines released, empties the output register, clears device_address and
//   sets phase_ticks to 100.
module i2c_register_transfer_master_unit #(
    parameter int COUNT_WIDTH = i2crt_pkg::COUNT_WIDTH_DEF,
    parameter int DELAY_WIDTH = i2crt_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2crt_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [i2crt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [i2crt_pkg::ACTION_W-1:0]      i_action,
    input  logic [i2crt_pkg::BYTE_W-1:0]        i_reg_addr,
    input  logic                                i_read_not_write,
    input  logic [i2crt_pkg::COUNT_IN_W-1:0]    i_byte_count,
    input  logic [i2crt_pkg::BYTE_W-1:0]        i_write_byte,
    input  logic                                i_sda_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic [i2crt_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                                o_read_valid,
    output logic                                o_write_request,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic                                o_status
);
    import i2crt_pkg::*;

    logic [DEV_ADDR_W-1:0] r_dev_addr;
    logic [PHASE_W-1:0]    r_phase_ticks;
    logic                  r_out_valid;
    t_result               r_out;
    t_cfg                  cfg;
    t_item                 item;
    t_result               core_res;
    logic                  accept;
    logic                  cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= '0;
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[DEV_ADDR_W-1:0];
                REG_PHASE_TICKS: r_phase_ticks <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.dev_addr    = r_dev_addr;
    assign cfg.phase_ticks = r_phase_ticks;

    assign item.action         = i_action;
    assign item.reg_addr       = i_reg_addr;
    assign item.read_not_write = i_read_not_write;
    assign item.byte_count     = i_byte_count;
    assign item.write_byte     = i_write_byte;
    assign item.sda_in         = i_sda_in;

    // A new word is taken whenever the result register is empty or drains now.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    i2crt_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_cfg   (cfg),
        .i_item  (item),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl_level     = r_out.scl_level;
    assign o_sda_level     = r_out.sda_level;
    assign o_read_byte     = r_out.read_byte;
    assign o_read_valid    = r_out.read_valid;
    assign o_write_request = r_out.write_request;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_status        = r_out.status;

endmodule

>>> design/i2crt_core.sv
`timescale 1ns / 1ps
// Bus sequencer of the I2C register-transfer master: state registers and the
// per-tick next-state logic. Depends on i2crt_pkg.
module i2crt_core #(
    parameter int COUNT_WIDTH = i2crt_pkg::COUNT_WIDTH_DEF,
    parameter int DELAY_WIDTH = i2crt_pkg::DELAY_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  i2crt_pkg::t_cfg    i_cfg,
    input  i2crt_pkg::t_item   i_item,
    output i2crt_pkg::t_result o_res
);
    import i2crt_pkg::*;

    localparam int CntInW = (COUNT_WIDTH < COUNT_IN_W) ? COUNT_WIDTH : COUNT_IN_W;
    localparam int DlyInW = (DELAY_WIDTH < PHASE_W) ? DELAY_WIDTH : PHASE_W;

    typedef struct packed {
        t_stage           stage;
        logic [SUB_W-1:0] sub;
        logic             scl;
        logic             sda;
    } t_step;

    function automatic t_step mk_step(t_stage stage, logic [SUB_W-1:0] sub,
                                      logic scl, logic sda);
        t_step s;
        s.stage = stage;
        s.sub   = sub;
        s.scl   = scl;
        s.sda   = sda;
        return s;
    endfunction

    t_stage                 r_stage, n_stage;
    logic [SUB_W-1:0]       r_sub, n_sub;
    logic [DELAY_WIDTH-1:0] r_tick, n_tick;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [BYTE_W-1:0]      r_shift, n_shift;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic [BYTE_W-1:0]      r_held_reg, n_held_reg;
    logic                   r_dir, n_dir;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;

    logic [DELAY_WIDTH-1:0] phase_trunc;
    logic [DELAY_WIDTH-1:0] load;
    logic [DELAY_WIDTH-1:0] tick_dec;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] left_dec;
    logic [BYTE_W-1:0]      dev_w;
    logic [BYTE_W-1:0]      dev_d;
    logic [BIT_CNT_W-1:0]   bit_inc;
    logic [BYTE_W-1:0]      send_shift;
    logic [BYTE_W-1:0]      recv_shift;
    logic                   do_ent;
    logic                   do_idle;
    t_step                  ent;
    t_result                res;

    assign phase_trunc = DELAY_WIDTH'(i_cfg.phase_ticks[DlyInW-1:0]);
    assign load        = (phase_trunc == '0) ? DELAY_WIDTH'(1) : phase_trunc;
    assign tick_dec    = r_tick - DELAY_WIDTH'(r_tick != '0);
    assign count       = COUNT_WIDTH'(i_item.byte_count[CntInW-1:0]);
    assign left_dec    = r_left - COUNT_WIDTH'(r_left != '0);
    assign dev_w       = {i_cfg.dev_addr, 1'b0};
    assign dev_d       = {i_cfg.dev_addr, r_dir ? READ_BIT : 1'b0};
    assign bit_inc     = r_bit + BIT_CNT_W'(1);
    assign send_shift  = {r_shift[BYTE_W-2:0], 1'b0};
    assign recv_shift  = {r_shift[BYTE_W-2:0], i_item.sda_in};

    always_comb begin
        n_stage    = r_stage;
        n_sub      = r_sub;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_left     = r_left;
        n_held_reg = r_held_reg;
        n_dir      = r_dir;
        n_scl      = r_scl;
        n_sda      = r_sda;
        do_ent     = 1'b0;
        do_idle    = 1'b0;
        ent        = mk_step(ST_IDLE, SUB_DRIVE, 1'b1, 1'b1);
        res        = '0;

        if (r_stage == ST_IDLE) begin
            if (i_item.action == ACT_BEGIN) begin
                if (i_item.reg_addr == '0) begin
                    res.done_res = 1'b1;
                    res.status   = 1'b1;
                end else if (count == '0) begin
                    res.done_res = 1'b1;
                end else begin
                    n_held_reg = i_item.reg_addr;
                    n_dir      = i_item.read_not_write;
                    n_left     = count;
                    ent        = mk_step(ST_START1, SUB_DRIVE, 1'b1, 1'b1);
                    do_ent     = 1'b1;
                end
            end
        end else if (r_stage == ST_DATA && r_sub == SUB_WAIT) begin
            if (i_item.action == ACT_SUPPLY) begin
                n_left  = left_dec;
                n_shift = i_item.write_byte;
                n_bit   = '0;
                ent     = mk_step(ST_DATA, SUB_DRIVE, 1'b0, i_item.write_byte[BYTE_W-1]);
                do_ent  = 1'b1;
            end
        end else begin
            n_tick = tick_dec;
            if (tick_dec == '0) begin
                case (r_stage)
                    ST_START1, ST_START2: begin
                        if (r_sub == SUB_DRIVE) begin
                            ent    = mk_step(r_stage, SUB_HIGH, 1'b1, 1'b0);
                            do_ent = 1'b1;
                        end else if (r_sub == SUB_HIGH) begin
                            // Load the device address byte that follows the start.
                            n_shift = (r_stage == ST_START1) ? dev_w : dev_d;
                            n_bit   = '0;
                            ent     = (r_stage == ST_START1)
                                    ? mk_step(ST_DEVW, SUB_DRIVE, 1'b0, dev_w[BYTE_W-1])
                                    : mk_step(ST_DEVD, SUB_DRIVE, 1'b0, dev_d[BYTE_W-1]);
                            do_ent  = 1'b1;
                        end else begin
                            do_idle = 1'b1;
                        end
                    end
                    ST_DEVW, ST_REG, ST_DEVD, ST_DATA: begin
                        if (r_stage == ST_DATA && r_dir) begin
                            case (r_sub)
                                SUB_DRIVE: begin
                                    ent    = mk_step(ST_DATA, SUB_HIGH, 1'b1, 1'b1);
                                    do_ent = 1'b1;
                                end
                                SUB_HIGH: begin
                                    n_shift = recv_shift;
                                    n_bit   = bit_inc;
                                    do_ent  = 1'b1;
                                    if (bit_inc >= BIT_CNT_W'(8)) begin
                                        // The last byte of the transfer is NACKed.
                                        res.read_byte  = recv_shift;
                                        res.read_valid = 1'b1;
                                        n_left         = left_dec;
                                        ent = mk_step(ST_DATA, SUB_ACK_LOW, 1'b0,
                                                      r_left <= COUNT_WIDTH'(1));
                                    end else begin
                                        ent = mk_step(ST_DATA, SUB_DRIVE, 1'b0, 1'b1);
                                    end
                                end
                                SUB_ACK_LOW: begin
                                    ent    = mk_step(ST_DATA, SUB_ACK_HIGH, 1'b1, r_sda);
                                    do_ent = 1'b1;
                                end
                                SUB_ACK_HIGH: begin
                                    ent    = mk_step(ST_DATA, SUB_ACK_END, 1'b0, r_sda);
                                    do_ent = 1'b1;
                                end
                                SUB_ACK_END: begin
                                    do_ent = 1'b1;
                                    if (r_left != '0) begin
                                        n_shift = '0;
                                        n_bit   = '0;
                                        ent = mk_step(ST_DATA, SUB_DRIVE, 1'b0, 1'b1);
                                    end else begin
                                        ent = mk_step(ST_STOP, SUB_DRIVE, 1'b0, 1'b0);
                                    end
                                end
                                default: do_idle = 1'b1;
                            endcase
                        end else begin
                            case (r_sub)
                                SUB_DRIVE: begin
                                    ent    = mk_step(r_stage, SUB_HIGH, 1'b1, r_sda);
                                    do_ent = 1'b1;
                                end
                                SUB_HIGH: begin
                                    n_shift = send_shift;
                                    n_bit   = bit_inc;
                                    do_ent  = 1'b1;
                                    if (bit_inc >= BIT_CNT_W'(8)) begin
                                        ent = mk_step(r_stage, SUB_ACK_LOW, 1'b0, 1'b1);
                                    end else begin
                                        ent = mk_step(r_stage, SUB_DRIVE, 1'b0,
                                                      send_shift[BYTE_W-1]);
                                    end
                                end
                                SUB_ACK_LOW: begin
                                    ent    = mk_step(r_stage, SUB_ACK_HIGH, 1'b1, 1'b1);
                                    do_ent = 1'b1;
                                end
                                SUB_ACK_HIGH: begin
                                    ent    = mk_step(r_stage, SUB_ACK_END, 1'b0, 1'b1);
                                    do_ent = 1'b1;
                                end
                                SUB_ACK_END: begin
                                    if (r_stage == ST_DEVW) begin
                                        n_shift = r_held_reg;
                                        n_bit   = '0;
                                        ent     = mk_step(ST_REG, SUB_DRIVE, 1'b0,
                                                          r_held_reg[BYTE_W-1]);
                                        do_ent  = 1'b1;
                                    end else if (r_stage == ST_REG) begin
                                        ent    = mk_step(ST_START2, SUB_DRIVE, 1'b1, 1'b1);
                                        do_ent = 1'b1;
                                    end else if (r_left == '0) begin
                                        ent    = mk_step(ST_STOP, SUB_DRIVE, 1'b0, 1'b0);
                                        do_ent = 1'b1;
                                    end else if (r_dir) begin
                                        n_shift = '0;
                                        n_bit   = '0;
                                        ent     = mk_step(ST_DATA, SUB_DRIVE, 1'b0, 1'b1);
                                        do_ent  = 1'b1;
                                    end else begin
                                        // Park with SCL low until the caller supplies a byte.
                                        n_stage = ST_DATA;
                                        n_sub   = SUB_WAIT;
                                        n_scl   = 1'b0;
                                        n_sda   = 1'b1;
                                        n_tick  = '0;
                                    end
                                end
                                default: do_idle = 1'b1;
                            endcase
                        end
                    end
                    ST_STOP: begin
                        if (r_sub == SUB_DRIVE) begin
                            ent    = mk_step(ST_STOP, SUB_HIGH, 1'b1, 1'b0);
                            do_ent = 1'b1;
                        end else begin
                            do_idle      = 1'b1;
                            res.done_res = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
            end
        end

        if (do_ent) begin
            n_stage = ent.stage;
            n_sub   = ent.sub;
            n_scl   = ent.scl;
            n_sda   = ent.sda;
            n_tick  = load;
        end
        if (do_idle) begin
            n_stage = ST_IDLE;
            n_sub   = SUB_DRIVE;
            n_tick  = '0;
            n_scl   = 1'b1;
            n_sda   = 1'b1;
        end

        res.scl_level     = n_scl;
        res.sda_level     = n_sda;
        res.write_request = (n_stage == ST_DATA) && (n_sub == SUB_WAIT);
        res.busy_res      = (n_stage != ST_IDLE);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= ST_IDLE;
            r_sub      <= SUB_DRIVE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_left     <= '0;
            r_held_reg <= '0;
            r_dir      <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else if (i_en) begin
            r_stage    <= n_stage;
            r_sub      <= n_sub;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_left     <= n_left;
            r_held_reg <= n_held_reg;
            r_dir      <= n_dir;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    a_stage_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_stage))
        else $error("sequencer stage is not one-hot");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_IDLE) |-> (r_scl && r_sda && r_tick == '0))
        else $error("idle with a line pulled low or a timer running");

    a_wait_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_DATA && r_sub == SUB_WAIT) |-> (!r_dir && !r_scl))
        else $error("waiting for a write byte during a read or with SCL released");

    a_read_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.read_valid) |-> (r_dir && r_stage == ST_DATA))
        else $error("read byte produced outside a read data stage");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.done_res) |=> (r_stage == ST_IDLE))
        else $error("transfer reported done but the sequencer is not idle");

endmodule
